### rtl/cks_pkg.sv
// Package with the key, operator, error and sequencer codes of the calculator core.
`default_nettype none

package cks_pkg;

  typedef enum logic [3:0] {
    REQ_OPERATOR   = 4'd0,
    REQ_DIGIT      = 4'd1,
    REQ_BACKSPACE  = 4'd2,
    REQ_EQUAL      = 4'd3,
    REQ_CLEAR      = 4'd4,
    REQ_CLEAR_ALL  = 4'd5,
    REQ_MEM_CLEAR  = 4'd6,
    REQ_MEM_RECALL = 4'd7,
    REQ_MEM_ADD    = 4'd8,
    REQ_MEM_SUB    = 4'd9,
    REQ_MEM_STORE  = 4'd10,
    REQ_DECIMAL    = 4'd11
  } req_t;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_ADD    = 4'd1,
    OP_SUB    = 4'd2,
    OP_MUL    = 4'd3,
    OP_DIV    = 4'd4,
    OP_MOD    = 4'd5,
    OP_SQUARE = 4'd6,
    OP_SQRT   = 4'd7,
    OP_NEG    = 4'd8,
    OP_PCT    = 4'd9,
    OP_RECIP  = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_DIVZERO = 2'd1,
    ERR_ROOTNEG = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    UOP_MUL  = 2'd0,
    UOP_DIV  = 2'd1,
    UOP_SQRT = 2'd2
  } unit_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_APPLY,
    ST_WAIT,
    ST_AFTER,
    ST_PHASE_B,
    ST_FINAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  localparam int TEN     = 10;
  localparam int HUNDRED = 100;

  function automatic logic is_unary(op_t op);
    is_unary = (op >= OP_SQUARE) && (op <= OP_RECIP);
  endfunction

endpackage

`default_nettype wire

### rtl/calculator_key_sequencer_core.sv
// Top level of the calculator key sequencer: key decoding, state and result output.
//
// Usage. One key event comes in per input beat: s_tuser carries the key kind,
// s_tdata the operator code and the digit. Every key event gives exactly one
// output beat on m_tdata with the state after that key: entry value,
// accumulator, pending operator, memory, memory valid flag and error code.
// All values are WIDTH-bit two's complement, sign-extended to 64 bits.
// Sequencing. Keys are handled one at a time: a key is accepted only in the
// idle state, and the next one only after the result of the last has been
// written to the output register. Multiply, divide, modulo, square, percent,
// reciprocal and backspace run the bit-serial unit, and square root runs it
// as well; an operator key can chain two such runs.
// Stalls. A result waits in the output register while m_tready is low; the
// next key is still accepted and worked on, and only its final write waits
// for the output register to free up.
// Reset. rst is synchronous and active high; it clears accumulator, entry,
// pending operator, memory and both valid flags, and drops m_tvalid.
`default_nettype none

module calculator_key_sequencer_core import cks_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // op_code [3:0], digit [7:4]
  input  logic [3:0]   s_tuser,   // req_type [3:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [199:0] m_tdata    // entry_value [63:0], accumulator [127:64],
                                  // pending_op [131:128], memory_value [195:132],
                                  // memory_valid [196], error_code [198:197], zero
);

  state_t           state, state_next;
  logic [WIDTH-1:0] acc, acc_next;
  logic [WIDTH-1:0] entry, entry_next;
  op_t              op_reg, op_next;
  logic             ev, ev_next;
  logic [WIDTH-1:0] mem, mem_next;
  logic             mv, mv_next;
  err_t             err, err_next;
  op_t              cur, cur_next;
  logic             phase, phase_next;

  // Latched key event.
  logic [3:0]       req_q;
  op_t              opin_q;
  logic [3:0]       dig_q;

  unit_req_t        ureq;
  unit_stat_t       ustat;
  logic [WIDTH-1:0] ua;
  logic [WIDTH-1:0] ub;
  logic [WIDTH-1:0] uquo;
  logic [WIDTH-1:0] urem;
  logic [WIDTH-1:0] src;
  logic             load_out;

  cks_serial_unit #(.WIDTH(WIDTH)) u_serial (
    .clk  (clk),
    .rst  (rst),
    .req  (ureq),
    .a    (ua),
    .b    (ub),
    .stat (ustat),
    .quo  (uquo),
    .rem  (urem)
  );

  // Memory keys work on the entry once one was keyed, else on the accumulator.
  assign src = ev ? entry : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      acc    <= '0;
      entry  <= '0;
      op_reg <= OP_NONE;
      ev     <= 1'b0;
      mem    <= '0;
      mv     <= 1'b0;
      err    <= ERR_NONE;
      cur    <= OP_NONE;
      phase  <= 1'b0;
    end else begin
      state  <= state_next;
      acc    <= acc_next;
      entry  <= entry_next;
      op_reg <= op_next;
      ev     <= ev_next;
      mem    <= mem_next;
      mv     <= mv_next;
      err    <= err_next;
      cur    <= cur_next;
      phase  <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_q  <= s_tuser;
      // Operator codes beyond the list behave as no operator.
      opin_q <= (s_tdata[3:0] > OP_RECIP) ? OP_NONE : op_t'(s_tdata[3:0]);
      dig_q  <= s_tdata[7:4];
    end
  end

  always_comb begin
    state_next = state;
    acc_next   = acc;
    entry_next = entry;
    op_next    = op_reg;
    ev_next    = ev;
    mem_next   = mem;
    mv_next    = mv;
    err_next   = err;
    cur_next   = cur;
    phase_next = phase;
    ureq.start = 1'b0;
    ureq.op    = UOP_MUL;
    ua         = acc;
    ub         = entry;
    load_out   = 1'b0;
    s_tready   = 1'b0;

    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          err_next   = ERR_NONE;
          state_next = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        state_next = ST_DONE;
        case (req_q)
          REQ_OPERATOR: begin
            // A pending binary operator (or none) is resolved first.
            if (!is_unary(op_reg)) begin
              cur_next   = op_reg;
              phase_next = 1'b0;
              state_next = ST_APPLY;
            end else begin
              state_next = ST_PHASE_B;
            end
          end
          REQ_EQUAL: begin
            cur_next   = op_reg;
            phase_next = 1'b0;
            state_next = ST_APPLY;
          end
          REQ_DIGIT: begin
            entry_next = {entry[WIDTH-4:0], 3'b000} + {entry[WIDTH-2:0], 1'b0}
                         + WIDTH'(dig_q);
            ev_next    = 1'b1;
          end
          REQ_BACKSPACE: begin
            ureq.start = 1'b1;
            ureq.op    = UOP_DIV;
            ua         = entry;
            ub         = WIDTH'(TEN);
            state_next = ST_WAIT;
          end
          REQ_CLEAR: entry_next = '0;
          REQ_CLEAR_ALL: begin
            acc_next   = '0;
            entry_next = '0;
            ev_next    = 1'b0;
            op_next    = OP_NONE;
          end
          REQ_MEM_CLEAR: begin
            mv_next  = 1'b0;
            mem_next = '0;
          end
          REQ_MEM_RECALL: begin
            entry_next = mem;
            ev_next    = 1'b1;
          end
          REQ_MEM_ADD: begin
            mem_next = mv ? mem + src : src;
            mv_next  = 1'b1;
          end
          REQ_MEM_SUB: begin
            mem_next = mv ? mem - src : WIDTH'(0) - src;
            mv_next  = 1'b1;
          end
          REQ_MEM_STORE: begin
            mem_next = src;
            mv_next  = 1'b1;
          end
          default: ;
        endcase
      end

      ST_APPLY: begin
        state_next = ST_AFTER;
        case (cur) inside
          OP_ADD: acc_next = acc + entry;
          OP_SUB: acc_next = acc - entry;
          OP_NEG: begin
            acc_next   = entry;
            entry_next = WIDTH'(0) - entry;
          end
          OP_MUL: begin
            ureq.start = 1'b1;
            ureq.op    = UOP_MUL;
            state_next = ST_WAIT;
          end
          OP_DIV, OP_MOD: begin
            if (entry == '0) begin
              err_next = ERR_DIVZERO;
            end else begin
              ureq.start = 1'b1;
              ureq.op    = UOP_DIV;
              state_next = ST_WAIT;
            end
          end
          OP_SQUARE: begin
            ureq.start = 1'b1;
            ureq.op    = UOP_MUL;
            ua         = entry;
            state_next = ST_WAIT;
          end
          OP_SQRT: begin
            if (entry[WIDTH-1]) begin
              err_next = ERR_ROOTNEG;
            end else begin
              ureq.start = 1'b1;
              ureq.op    = UOP_SQRT;
              ua         = entry;
              state_next = ST_WAIT;
            end
          end
          OP_PCT: begin
            ureq.start = 1'b1;
            ureq.op    = UOP_DIV;
            ua         = entry;
            ub         = WIDTH'(HUNDRED);
            state_next = ST_WAIT;
          end
          OP_RECIP: begin
            if (entry == '0) begin
              err_next = ERR_DIVZERO;
            end else begin
              ureq.start = 1'b1;
              ureq.op    = UOP_DIV;
              ua         = WIDTH'(1);
              state_next = ST_WAIT;
            end
          end
          default: acc_next = entry;
        endcase
      end

      ST_WAIT: begin
        if (ustat.done) begin
          if (req_q == REQ_BACKSPACE) begin
            entry_next = uquo;
            state_next = ST_DONE;
          end else begin
            state_next = ST_AFTER;
            case (cur) inside
              OP_MUL, OP_DIV: acc_next = uquo;
              OP_MOD:         acc_next = urem;
              default: begin
                // Unary operators keep the operand in the accumulator.
                acc_next   = entry;
                entry_next = uquo;
              end
            endcase
          end
        end
      end

      ST_AFTER: begin
        if (req_q == REQ_EQUAL) begin
          entry_next = acc;
          acc_next   = '0;
          ev_next    = 1'b1;
          op_next    = OP_NONE;
          state_next = ST_DONE;
        end else if (!phase) begin
          state_next = ST_PHASE_B;
        end else begin
          state_next = ST_FINAL;
        end
      end

      ST_PHASE_B: begin
        if (is_unary(opin_q)) begin
          // After a binary operator the running result is the operand.
          if (!is_unary(op_reg) && op_reg != OP_NONE) begin
            entry_next = acc;
          end
          cur_next   = opin_q;
          phase_next = 1'b1;
          state_next = ST_APPLY;
        end else begin
          state_next = ST_FINAL;
        end
      end

      ST_FINAL: begin
        op_next = opin_q;
        if (!is_unary(opin_q)) begin
          entry_next = '0;
        end
        ev_next    = 1'b1;
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {1'b0, err, mv, 64'($signed(mem)), op_reg,
                  64'($signed(acc)), 64'($signed(entry))};
    end
  end

  // The serial unit reports completion only to a sequencer that waits for it.
  assert property (@(posedge clk) disable iff (rst) ustat.done |-> state == ST_WAIT)
    else $error("serial unit finished outside the wait state");

  // While waiting, the serial unit is running or has just finished.
  assert property (@(posedge clk) disable iff (rst)
                   state == ST_WAIT |-> ustat.busy || ustat.done)
    else $error("sequencer waits on an idle serial unit");

endmodule

`default_nettype wire

### rtl/cks_serial_unit.sv
// Bit-serial multiply, signed divide and square root unit of the calculator core.
`default_nettype none

module cks_serial_unit import cks_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  unit_req_t        req,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output unit_stat_t       stat,
  output logic [WIDTH-1:0] quo,
  output logic [WIDTH-1:0] rem
);

  localparam int CW   = $clog2(WIDTH + 1);
  localparam int HALF = (WIDTH + 1) / 2;
  localparam int WP   = 2 * HALF;
  localparam int RW   = WIDTH + 2;

  logic             busy;
  logic             done;
  unit_op_t         op_q;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] xr;
  logic [WIDTH-1:0] yr;
  logic [WIDTH-1:0] pr;
  logic [RW-1:0]    rr;
  logic [WP-1:0]    sx;
  logic             neg_q;
  logic             neg_r;

  logic [WIDTH:0]   div_t;
  logic             div_ge;
  logic [RW-1:0]    sq_t;
  logic [RW-1:0]    sq_trial;
  logic             sq_ge;

  // One quotient bit per cycle: shift in the next dividend bit, then trial subtract.
  assign div_t    = {rr[WIDTH-1:0], xr[WIDTH-1]};
  assign div_ge   = div_t >= {1'b0, yr};
  // One root bit per cycle from two radicand bits.
  assign sq_t     = {rr[RW-3:0], sx[WP-1:WP-2]};
  assign sq_trial = {pr, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_q  <= req.op;
      neg_q <= a[WIDTH-1] ^ b[WIDTH-1];
      neg_r <= a[WIDTH-1];
      rr    <= '0;
      pr    <= '0;
      unique case (req.op)
        UOP_DIV: begin
          xr  <= a[WIDTH-1] ? WIDTH'(0) - a : a;
          yr  <= b[WIDTH-1] ? WIDTH'(0) - b : b;
          cnt <= CW'(WIDTH);
        end
        UOP_SQRT: begin
          sx  <= WP'(a);
          cnt <= CW'(HALF);
        end
        default: begin
          xr  <= a;
          yr  <= b;
          cnt <= CW'(WIDTH);
        end
      endcase
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      unique case (op_q)
        UOP_DIV: begin
          rr <= div_ge ? RW'(div_t - {1'b0, yr}) : RW'(div_t);
          xr <= {xr[WIDTH-2:0], div_ge};
        end
        UOP_SQRT: begin
          rr <= sq_ge ? sq_t - sq_trial : sq_t;
          pr <= {pr[WIDTH-2:0], sq_ge};
          sx <= {sx[WP-3:0], 2'b00};
        end
        default: begin
          pr <= {pr[WIDTH-2:0], 1'b0} + (yr[WIDTH-1] ? xr : WIDTH'(0));
          yr <= {yr[WIDTH-2:0], 1'b0};
        end
      endcase
    end
  end

  always_comb begin
    rem = neg_r ? WIDTH'(0) - rr[WIDTH-1:0] : rr[WIDTH-1:0];
    case (op_q)
      UOP_DIV: quo = neg_q ? WIDTH'(0) - xr : xr;
      default: quo = pr;
    endcase
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

### test/calculator_key_sequencer_core_tb.sv
// Self-checking testbench for the calculator key sequencer core with a built-in predictor.
`default_nettype none

module calculator_key_sequencer_core_tb;
  import cks_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD = 600;

  typedef struct packed {
    logic [3:0] req;
    logic [3:0] op;
    logic [3:0] dig;
  } key_t;

  // Laid out as on m_tdata, first field in the highest bits.
  typedef struct packed {
    logic [1:0]  err;
    logic        memv;
    logic [63:0] mem;
    logic [3:0]  pend;
    logic [63:0] acc;
    logic [63:0] entry;
  } calc_state_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;
  logic [3:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [199:0] m_tdata;

  calculator_key_sequencer_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state, mirroring the block's registers.
  logic [63:0] acc_q, entry_q, mem_q;
  logic [3:0]  pend_q;
  logic        entry_v, mem_v;
  logic [1:0]  err_q;

  key_t        keys_pending[$];
  calc_state_t results_due[$];
  int          errors = 0;
  int          n_keys = 0;
  bit          calm = 0;
  bit          hold_long = 0;

  function automatic logic [63:0] sdiv(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic logic [63:0] smod(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, r;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    r = ma % mb;
    return a[63] ? -r : r;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic bit unary_code(logic [3:0] op);
    return op >= OP_SQUARE && op <= OP_RECIP;
  endfunction

  // Applies one operator to accumulator and entry, as the block does.
  task automatic run_op(logic [3:0] op);
    logic [63:0] v;
    v = entry_q;
    if (!entry_v) pend_q = op;
    case (op)
      OP_ADD: acc_q = acc_q + v;
      OP_SUB: acc_q = acc_q - v;
      OP_MUL: acc_q = acc_q * v;
      OP_DIV: if (v == 0) err_q = ERR_DIVZERO; else acc_q = sdiv(acc_q, v);
      OP_MOD: if (v == 0) err_q = ERR_DIVZERO; else acc_q = smod(acc_q, v);
      OP_SQUARE: begin acc_q = v; entry_q = v * v; pend_q = OP_NONE; end
      OP_SQRT:
        if (v[63]) err_q = ERR_ROOTNEG;
        else begin acc_q = v; entry_q = isqrt(v); pend_q = OP_NONE; end
      OP_NEG: begin acc_q = v; entry_q = -v; pend_q = OP_NONE; end
      OP_PCT: begin acc_q = v; entry_q = sdiv(v, HUNDRED); pend_q = OP_NONE; end
      OP_RECIP:
        if (v == 0) err_q = ERR_DIVZERO;
        else begin acc_q = v; entry_q = sdiv(64'd1, v); pend_q = OP_NONE; end
      default: acc_q = v;
    endcase
  endtask

  task automatic predict_key(key_t k);
    logic [3:0] op;
    logic [63:0] src;
    calc_state_t r;
    op = (k.op > OP_RECIP) ? OP_NONE : k.op;
    err_q = ERR_NONE;
    src = entry_v ? entry_q : acc_q;
    case (k.req)
      REQ_OPERATOR: begin
        if (!unary_code(pend_q)) run_op(pend_q);
        if (unary_code(op)) begin
          if (!unary_code(pend_q) && pend_q != OP_NONE) entry_q = acc_q;
          run_op(op);
        end
        pend_q = op;
        if (!unary_code(op)) entry_q = 0;
        entry_v = 1;
      end
      REQ_DIGIT: begin entry_q = entry_q * TEN + k.dig; entry_v = 1; end
      REQ_BACKSPACE: entry_q = sdiv(entry_q, TEN);
      REQ_EQUAL: begin
        run_op(pend_q);
        entry_q = acc_q; acc_q = 0; entry_v = 1; pend_q = OP_NONE;
      end
      REQ_CLEAR: entry_q = 0;
      REQ_CLEAR_ALL: begin acc_q = 0; entry_q = 0; entry_v = 0; pend_q = OP_NONE; end
      REQ_MEM_CLEAR: begin mem_v = 0; mem_q = 0; end
      REQ_MEM_RECALL: begin entry_q = mem_q; entry_v = 1; end
      REQ_MEM_ADD: begin mem_q = mem_v ? mem_q + src : src; mem_v = 1; end
      REQ_MEM_SUB: begin mem_q = mem_v ? mem_q - src : -src; mem_v = 1; end
      REQ_MEM_STORE: begin mem_q = src; mem_v = 1; end
      default: ;
    endcase
    r.entry = entry_q; r.acc = acc_q; r.pend = pend_q;
    r.mem = mem_q; r.memv = mem_v; r.err = err_q;
    results_due.push_back(r);
  endtask

  // Random 64-bit value, biased toward extremes and small numbers.
  function automatic logic [63:0] rand_big();
    case ($urandom_range(0, 5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return {$urandom, $urandom};
      default: return $urandom_range(0, 2000);
    endcase
  endfunction

  task automatic push_key(logic [3:0] req, logic [3:0] op, logic [3:0] dig);
    key_t k;
    k.req = req; k.op = op; k.dig = dig;
    keys_pending.push_back(k);
    n_keys++;
  endtask

  // Enters a non-negative number with digit keys, most significant first.
  task automatic push_number(int unsigned n);
    int unsigned d[$];
    do begin d.push_front(n % 10); n = n / 10; end while (n != 0);
    foreach (d[i]) push_key(REQ_DIGIT, 4'($urandom_range(0, 15)), 4'(d[i]));
  endtask

  // Driver: offers the next pending key, idling in random bursts.
  int gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_key({s_tuser, s_tdata[3:0], s_tdata[7:4]});
      end
      if (!s_tvalid || s_tready) begin
        if (gap > 0) begin
          gap <= gap - 1;
          s_tvalid <= 1'b0;
        end else if (keys_pending.size() > 0) begin
          key_t k;
          k = keys_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= k.req;
          s_tdata <= {k.dig, k.op};
          if (!calm && $urandom_range(0, 7) == 0) gap <= $urandom_range(1, 15);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the receiver, counted once it is requested.
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
    end else if (hold_long && hold_cnt < LONG_HOLD) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  // Monitor: compares each output beat with the oldest prediction.
  int stall = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        calc_state_t got, want;
        got = m_tdata[198:0];
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (got.entry !== want.entry) begin
            $display("%0t: entry_value exp %h got %h", $time, want.entry, got.entry);
            errors++;
          end
          if (got.acc !== want.acc) begin
            $display("%0t: accumulator exp %h got %h", $time, want.acc, got.acc);
            errors++;
          end
          if (got.pend !== want.pend) begin
            $display("%0t: pending_op exp %0d got %0d", $time, want.pend, got.pend);
            errors++;
          end
          if (got.mem !== want.mem) begin
            $display("%0t: memory_value exp %h got %h", $time, want.mem, got.mem);
            errors++;
          end
          if (got.memv !== want.memv) begin
            $display("%0t: memory_valid exp %0d got %0d", $time, want.memv, got.memv);
            errors++;
          end
          if (got.err !== want.err) begin
            $display("%0t: error_code exp %0d got %0d", $time, want.err, got.err);
            errors++;
          end
        end
      end
      // A long hold-off lets the block fill up and stall its input.
      if (hold_long && hold_cnt < LONG_HOLD) begin
        m_tready <= 1'b0;
      end else if (stall > 0) begin
        stall <= stall - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) stall <= $urandom_range(1, 15);
      end
    end
  end

  initial begin
    acc_q = 0; entry_q = 0; pend_q = OP_NONE; entry_v = 0;
    mem_q = 0; mem_v = 0; err_q = ERR_NONE;

    // Directed keys: all operators but subtract, memory keys, errors and odd codes.
    push_number(32'hffff_ffff);
    push_key(REQ_OPERATOR, OP_ADD, 0);
    push_number(7);
    push_key(REQ_OPERATOR, OP_DIV, 0);
    push_key(REQ_OPERATOR, OP_MUL, 0);
    push_key(REQ_EQUAL, 0, 0);
    push_key(REQ_OPERATOR, OP_DIV, 0);
    push_key(REQ_EQUAL, 0, 0);
    push_key(REQ_OPERATOR, OP_MOD, 0);
    push_key(REQ_EQUAL, 0, 0);
    push_key(REQ_OPERATOR, OP_RECIP, 0);
    push_key(REQ_OPERATOR, OP_NEG, 9);
    push_key(REQ_OPERATOR, OP_SQRT, 0);
    push_key(REQ_OPERATOR, OP_SQUARE, 0);
    push_key(REQ_OPERATOR, OP_PCT, 0);
    push_key(REQ_OPERATOR, 4'd15, 15);
    push_key(REQ_DIGIT, OP_SUB, 15);
    push_key(REQ_BACKSPACE, 0, 0);
    push_key(REQ_MEM_SUB, 0, 0);
    push_key(REQ_MEM_ADD, 0, 0);
    push_key(REQ_MEM_RECALL, 0, 0);
    push_key(REQ_MEM_STORE, 0, 0);
    push_key(REQ_MEM_CLEAR, 0, 0);
    push_key(REQ_DECIMAL, 0, 0);
    push_key(4'd15, 0, 0);
    push_key(REQ_CLEAR, 0, 0);
    push_key(REQ_CLEAR_ALL, 0, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Random part: mostly well-formed expressions, some raw noise keys.
    while (n_keys < 1850) begin
      if (keys_pending.size() > 40) begin
        @(posedge clk);
        if (n_keys > 300 && n_keys < 400) hold_long <= 1'b1;
        continue;
      end
      if ($urandom_range(0, 4) == 0) begin
        push_key(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 4'($urandom_range(0, 15)));
      end else begin
        logic [63:0] v;
        v = rand_big();
        if (v < 64'd1_000_000) begin
          push_number(v[31:0]);
        end else begin
          // Large operands are built as the product of two keyed numbers.
          push_number(v[31:0]);
          push_key(REQ_OPERATOR, OP_MUL, 0);
          push_number(v[63:32] | 32'd1);
          push_key(REQ_EQUAL, 0, 0);
        end
        push_key(REQ_OPERATOR, 4'($urandom_range(0, 10)), 4'($urandom_range(0, 15)));
        if ($urandom_range(0, 1)) push_number($urandom_range(0, 300));
        if ($urandom_range(0, 2) == 0)
          push_key(4'($urandom_range(REQ_EQUAL, REQ_DECIMAL)), 0, 0);
        if ($urandom_range(0, 3) == 0) push_key(REQ_EQUAL, 0, 0);
      end
      if (n_keys > 1650) calm <= 1'b1;
    end

    while (keys_pending.size() > 0 || s_tvalid || results_due.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && results_due.size() == 0)
      $display("** calculator_key_sequencer_core: PASSED **");
    else
      $display("** calculator_key_sequencer_core: FAILED **");
    $finish;
  end

  initial begin
    #20ms;
    $display("** calculator_key_sequencer_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/cks_pkg.sv
rtl/cks_serial_unit.sv
rtl/calculator_key_sequencer_core.sv
test/calculator_key_sequencer_core_tb.sv
